// File: rtl/aqg_pkg.sv
// ----------------------------------------------------------------------------
// aqg_pkg
// Shared types, codes and constants of the adaptive quality governor.
// ----------------------------------------------------------------------------
package aqg_pkg;

  localparam int unsigned QUALITY_LEVELS_DEF    = 6;
  localparam int unsigned MAX_WINDOW_FRAMES_DEF = 4096;
  localparam int unsigned WINDOW_US_DEF         = 500000;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned QUAL_W    = 3;
  localparam int unsigned DT_W      = 20;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned RATE_W    = 24;
  localparam int unsigned PROD_W    = SCALE_W + DT_W;
  localparam int unsigned TARGET_W  = 10;
  localparam int unsigned IVL_W     = 26;
  localparam int unsigned IVL_LEFT_W = IVL_W + 1;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 26;
  localparam int unsigned S_DATA_W  = 40;
  localparam int unsigned M_DATA_W  = 32;

  localparam logic [DT_W-1:0]       USEC_PER_SEC = DT_W'(1000000);
  localparam logic [11:0]           MARGIN_Q8    = 12'd2560;

  localparam logic [TARGET_W-1:0]   TARGET_RST   = TARGET_W'(60);
  localparam logic [IVL_W-1:0]      INTERVAL_RST = IVL_W'(1000000);
  localparam logic [QUAL_W-1:0]     MIN_Q_RST    = QUAL_W'(0);
  localparam logic [QUAL_W-1:0]     MAX_Q_RST    = QUAL_W'(5);
  localparam logic [QUAL_W-1:0]     INIT_Q_RST   = QUAL_W'(2);

  typedef enum logic [ACTION_W-1:0] {
    ACT_FRAME  = 2'd0,
    ACT_SELECT = 2'd1,
    ACT_AUTO   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_ZERO_DT = 2'd1,
    STAT_BAD_SEL = 2'd2,
    STAT_BAD_CFG = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_FPS  = 3'd0,
    REG_INTERVAL_US = 3'd1,
    REG_MIN_QUALITY = 3'd2,
    REG_MAX_QUALITY = 3'd3,
    REG_INIT_QUALITY = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RATE_GO,
    ST_RATE_WAIT,
    ST_AVG_GO,
    ST_AVG_WAIT,
    ST_ADJUST,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// File: rtl/aqg_div.sv
// ----------------------------------------------------------------------------
// aqg_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aqg_div import aqg_pkg::*; #(
  parameter int unsigned DVD_W = 37,
  parameter int unsigned DVS_W = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output div_ctl_t         ctl_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.done  = done_q;
  assign quotient_o  = quo_q;

endmodule

// File: rtl/adaptive_quality_governor.sv
// ----------------------------------------------------------------------------
// adaptive_quality_governor
// Picks a rendering quality level from measured frame rates.
// ----------------------------------------------------------------------------
// One word in, one word out. A frame update multiplies the time scale by one
// million, then divides by the frame time on a shared one-bit-per-cycle
// divider; when the window closes the same divider forms the window average,
// a second pass of the same length. The input is not ready while a word is
// in progress; a finished result sits in the output register and the next
// word is taken meanwhile.
module adaptive_quality_governor import aqg_pkg::*; #(
  parameter int unsigned QUALITY_LEVELS    = QUALITY_LEVELS_DEF,
  parameter int unsigned MAX_WINDOW_FRAMES = MAX_WINDOW_FRAMES_DEF,
  parameter int unsigned WINDOW_US         = WINDOW_US_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // frame_time_us[19:0], time_scale[35:20], manual_quality[38:36],
  // automatic_on[39]
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // action[1:0]
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // status[1:0], quality[4:2], quality_changed[5], fps_average[29:6],
  // automatic_res[30], zero[31]
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FC_W  = $clog2(MAX_WINDOW_FRAMES + 1);
  localparam int unsigned ACC_W = RATE_W + FC_W;
  localparam int unsigned WU_W  = $clog2(WINDOW_US + 1);
  localparam int unsigned WL_W  = ((WU_W > DT_W) ? WU_W : DT_W) + 1;
  localparam int unsigned DIV_W = (ACC_W > PROD_W) ? ACC_W : PROD_W;
  localparam int unsigned DVS_W = (FC_W > DT_W) ? FC_W : DT_W;

  // configuration
  logic [TARGET_W-1:0] tgt_q, tgt_d;
  logic [IVL_W-1:0]    ivl_q, ivl_d;
  logic [QUAL_W-1:0]   minq_q, minq_d;
  logic [QUAL_W-1:0]   maxq_q, maxq_d;
  logic [QUAL_W-1:0]   initq_q, initq_d;

  // governor state
  state_e                 state_q, state_d;
  logic [QUAL_W-1:0]      qual_q, qual_d;
  logic                   auto_q, auto_d;
  logic signed [IVL_LEFT_W-1:0] ivleft_q, ivleft_d;
  logic signed [WL_W-1:0] win_q, win_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [FC_W-1:0]        frames_q, frames_d;
  logic [RATE_W-1:0]      avg_q, avg_d;
  status_e                stat_q, stat_d;
  logic                   chg_q, chg_d;

  // word in progress
  action_e             act_q;
  logic [DT_W-1:0]     dt_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [QUAL_W-1:0]   mq_q;
  logic                aon_q;
  logic [PROD_W-1:0]   prod_q, prod_d;

  // output register
  logic                m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0] m_data_q, m_data_d;

  logic                s_accept;
  logic                cfg_hit;
  logic                cfg_good_now;
  logic                div_start;
  logic [DIV_W-1:0]    div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  logic [DIV_W-1:0]    div_quo;
  div_ctl_t            div_ctl;
  logic [RATE_W-1:0]   rate;
  logic [ACC_W-1:0]    acc_sum;
  logic [FC_W-1:0]     frames_inc;
  logic signed [WL_W-1:0] win_sub;
  logic signed [IVL_LEFT_W-1:0] iv_sub;
  logic [RATE_W:0]     avg_up;
  logic [RATE_W:0]     tq;
  logic [RATE_W:0]     tq_up;

  function automatic logic cfg_ok(input logic [TARGET_W-1:0] t, input logic [IVL_W-1:0] iv,
                                  input logic [QUAL_W-1:0] lo, input logic [QUAL_W-1:0] hi,
                                  input logic [QUAL_W-1:0] ini);
    return (t != '0) && (iv != '0) && (lo <= ini) && (ini <= hi) &&
           (32'(hi) < QUALITY_LEVELS);
  endfunction

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign cfg_good_now = cfg_ok(tgt_q, ivl_q, minq_q, maxq_q, initq_q);

  assign rate       = (|div_quo[DIV_W-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];
  assign acc_sum    = acc_q + ACC_W'(rate);
  assign frames_inc = frames_q + 1'b1;
  assign win_sub    = win_q - $signed({{(WL_W-DT_W){1'b0}}, dt_q});
  assign iv_sub     = ivleft_q - $signed({{(IVL_LEFT_W-DT_W){1'b0}}, dt_q});
  assign avg_up     = {1'b0, avg_q} + (RATE_W+1)'(MARGIN_Q8);
  assign tq         = (RATE_W+1)'({tgt_q, 8'd0});
  assign tq_up      = tq + (RATE_W+1)'(MARGIN_Q8);

  assign div_start = (state_q == ST_RATE_GO) || (state_q == ST_AVG_GO);
  assign div_dvd   = (state_q == ST_AVG_GO) ? DIV_W'(acc_q) : DIV_W'(prod_q);
  assign div_dvs   = (state_q == ST_AVG_GO) ? DVS_W'(frames_q) : DVS_W'(dt_q);

  aqg_div #(
    .DVD_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .ctl_o      (div_ctl),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    qual_d    = qual_q;
    auto_d    = auto_q;
    ivleft_d  = ivleft_q;
    win_d     = win_q;
    acc_d     = acc_q;
    frames_d  = frames_q;
    avg_d     = avg_q;
    stat_d    = stat_q;
    chg_d     = chg_q;
    prod_d    = prod_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    tgt_d     = tgt_q;
    ivl_d     = ivl_q;
    minq_d    = minq_q;
    maxq_d    = maxq_q;
    initq_d   = initq_q;
    cfg_hit   = 1'b1;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        stat_d  = STAT_OK;
        chg_d   = 1'b0;
        state_d = ST_OUT;
        unique case (act_q)
          ACT_FRAME: begin
            if (!cfg_good_now) begin
              stat_d = STAT_BAD_CFG;
            end else if (dt_q == '0) begin
              stat_d = STAT_ZERO_DT;
            end else begin
              prod_d  = PROD_W'(scale_q) * PROD_W'(USEC_PER_SEC);
              state_d = ST_RATE_GO;
            end
          end
          ACT_SELECT: begin
            if (!cfg_good_now) begin
              stat_d = STAT_BAD_CFG;
            end else if ((mq_q < minq_q) || (mq_q > maxq_q)) begin
              stat_d = STAT_BAD_SEL;
            end else begin
              chg_d  = (mq_q != qual_q);
              qual_d = mq_q;
              auto_d = 1'b0;
            end
          end
          ACT_AUTO: begin
            auto_d = aon_q;
          end
          default: begin
          end
        endcase
      end
      ST_RATE_GO: begin
        state_d = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (div_ctl.done) begin
          acc_d    = acc_sum;
          frames_d = frames_inc;
          win_d    = win_sub;
          if ((win_sub <= 0) || (frames_inc >= FC_W'(MAX_WINDOW_FRAMES))) begin
            state_d = ST_AVG_GO;
          end else begin
            state_d = ST_ADJUST;
          end
        end
      end
      ST_AVG_GO: begin
        state_d = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (div_ctl.done) begin
          avg_d    = div_quo[RATE_W-1:0];
          win_d    = WL_W'(WINDOW_US);
          acc_d    = '0;
          frames_d = '0;
          state_d  = ST_ADJUST;
        end
      end
      ST_ADJUST: begin
        state_d = ST_OUT;
        if (auto_q) begin
          ivleft_d = iv_sub;
          if (iv_sub < 0) begin
            if ((avg_up >= tq) && (qual_q < maxq_q)) begin
              qual_d = qual_q + 1'b1;
              chg_d  = 1'b1;
            end else if (({1'b0, avg_q} <= tq_up) && (qual_q > minq_q)) begin
              qual_d = qual_q - 1'b1;
              chg_d  = 1'b1;
            end
            ivleft_d = $signed({1'b0, ivl_q});
          end
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = M_DATA_W'({auto_q, avg_q, chg_q, qual_q, stat_q});
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_FPS:   tgt_d   = cfg_data_i[TARGET_W-1:0];
        REG_INTERVAL_US:  ivl_d   = cfg_data_i[IVL_W-1:0];
        REG_MIN_QUALITY:  minq_d  = cfg_data_i[QUAL_W-1:0];
        REG_MAX_QUALITY:  maxq_d  = cfg_data_i[QUAL_W-1:0];
        REG_INIT_QUALITY: initq_d = cfg_data_i[QUAL_W-1:0];
        default:          cfg_hit = 1'b0;
      endcase
      if (cfg_hit && cfg_ok(tgt_d, ivl_d, minq_d, maxq_d, initq_d)) begin
        qual_d   = initq_d;
        chg_d    = 1'b0;
        ivleft_d = $signed({1'b0, ivl_d});
        win_d    = WL_W'(WINDOW_US);
        acc_d    = '0;
        frames_d = '0;
        avg_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tgt_q     <= TARGET_RST;
      ivl_q     <= INTERVAL_RST;
      minq_q    <= MIN_Q_RST;
      maxq_q    <= MAX_Q_RST;
      initq_q   <= INIT_Q_RST;
      qual_q    <= INIT_Q_RST;
      auto_q    <= 1'b1;
      ivleft_q  <= $signed({1'b0, INTERVAL_RST});
      win_q     <= WL_W'(WINDOW_US);
      acc_q     <= '0;
      frames_q  <= '0;
      avg_q     <= '0;
      stat_q    <= STAT_OK;
      chg_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tgt_q     <= tgt_d;
      ivl_q     <= ivl_d;
      minq_q    <= minq_d;
      maxq_q    <= maxq_d;
      initq_q   <= initq_d;
      qual_q    <= qual_d;
      auto_q    <= auto_d;
      ivleft_q  <= ivleft_d;
      win_q     <= win_d;
      acc_q     <= acc_d;
      frames_q  <= frames_d;
      avg_q     <= avg_d;
      stat_q    <= stat_d;
      chg_q     <= chg_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    m_data_q <= m_data_d;
    if (s_accept) begin
      act_q   <= action_e'(s_axis_tuser);
      dt_q    <= s_axis_tdata[19:0];
      scale_q <= s_axis_tdata[35:20];
      mq_q    <= s_axis_tdata[38:36];
      aon_q   <= s_axis_tdata[39];
    end
  end

endmodule
